@@ rtl/sdda_pkg.sv @@
// Shared types, widths and opcodes for the DDA stepper axis.
package sdda_pkg;

	localparam int POS_WIDTH_DEF = 32;
	localparam int OP_W = 3;
	localparam int VALUE_W = 32;
	localparam int DELTA_W = 31;
	localparam int ACC_W = 33;

	localparam logic [DELTA_W-1:0] DELTA_MAX = '1;
	localparam logic signed [ACC_W-1:0] ACC_MAX = {1'b0, {(ACC_W-1){1'b1}}};
	localparam logic signed [ACC_W-1:0] ACC_MIN = {1'b1, {(ACC_W-1){1'b0}}};

	typedef enum logic [OP_W-1:0] {
		OP_TICK   = 3'd0,
		OP_START  = 3'd1,
		OP_SETPOS = 3'd2,
		OP_JOGF   = 3'd3,
		OP_JOGR   = 3'd4
	} opcode_t;

	typedef struct packed {
		logic step_pulse;
		logic direction;
		logic may_step;
		logic on_target;
	} res_flags_t;

endpackage

@@ rtl/sdda_step.sv @@
// Next-state and result logic for one request applied to the axis state.
module sdda_step #(
	parameter int POS_WIDTH = sdda_pkg::POS_WIDTH_DEF
) (
	input  logic [sdda_pkg::OP_W-1:0]            op,
	input  logic signed [POS_WIDTH-1:0]          val,
	input  logic [sdda_pkg::DELTA_W-1:0]         mdelta,
	input  logic                                 min_sw,
	input  logic                                 max_sw,
	input  logic signed [POS_WIDTH-1:0]          pos_cur,
	input  logic signed [POS_WIDTH-1:0]          tgt_cur,
	input  logic                                 dir_cur,
	input  logic [sdda_pkg::DELTA_W-1:0]         delta_cur,
	input  logic signed [sdda_pkg::ACC_W-1:0]    acc_cur,
	input  logic [sdda_pkg::DELTA_W-1:0]         span_cur,
	output logic signed [POS_WIDTH-1:0]          pos_nxt,
	output logic signed [POS_WIDTH-1:0]          tgt_nxt,
	output logic                                 dir_nxt,
	output logic [sdda_pkg::DELTA_W-1:0]         delta_nxt,
	output logic signed [sdda_pkg::ACC_W-1:0]    acc_nxt,
	output logic [sdda_pkg::DELTA_W-1:0]         span_nxt,
	output sdda_pkg::res_flags_t                 flags
);
	import sdda_pkg::*;

	localparam int DW = (POS_WIDTH + 1 > 32) ? POS_WIDTH + 1 : 32;
	localparam int SW = ACC_W + 1;

	logic signed [POS_WIDTH-1:0] rc_tgt;
	logic signed [POS_WIDTH-1:0] rc_pos;
	logic signed [DW-1:0]        diff;
	logic [DW-1:0]               mag;
	logic                        rc_dir;
	logic [DELTA_W-1:0]          rc_delta;
	logic signed [SW-1:0]        sum;
	logic signed [SW-1:0]        sub;
	logic signed [ACC_W-1:0]     acc_add;
	logic signed [ACC_W-1:0]     acc_sub;
	logic                        tick_may;
	logic                        tick_step;
	logic                        pulse;
	logic signed [POS_WIDTH-1:0] pos_inc;
	logic signed [POS_WIDTH-1:0] pos_dec;

	function automatic logic allowed(input logic signed [POS_WIDTH-1:0] p,
			input logic signed [POS_WIDTH-1:0] t, input logic d,
			input logic mn, input logic mx);
		return (p != t) && !(mn && !d) && !(mx && d);
	endfunction

	// One shared direction/delta unit serves both start move and set position.
	assign rc_tgt = (op == OP_START) ? val : tgt_cur;
	assign rc_pos = (op == OP_SETPOS) ? val : pos_cur;
	assign diff = DW'(rc_tgt) - DW'(rc_pos);
	assign rc_dir = ~diff[DW-1];
	assign mag = diff[DW-1] ? $unsigned(-diff) : $unsigned(diff);
	assign rc_delta = (mag > DW'(DELTA_MAX)) ? DELTA_MAX : mag[DELTA_W-1:0];

	assign pos_inc = pos_cur + POS_WIDTH'(1);
	assign pos_dec = pos_cur - POS_WIDTH'(1);

	// DDA tick: saturating add of delta, then a saturating subtract of span on a step.
	assign tick_may = allowed(pos_cur, tgt_cur, dir_cur, min_sw, max_sw);
	assign sum = SW'(acc_cur) + SW'($signed({1'b0, delta_cur}));
	assign acc_add = (sum > SW'(ACC_MAX)) ? ACC_MAX : sum[ACC_W-1:0];
	assign tick_step = tick_may && !acc_add[ACC_W-1] && (acc_add != '0);
	assign sub = SW'(acc_add) - SW'($signed({2'b00, span_cur}));
	assign acc_sub = (sub < SW'(ACC_MIN)) ? ACC_MIN : sub[ACC_W-1:0];

	always_comb begin
		pos_nxt = pos_cur;
		tgt_nxt = tgt_cur;
		dir_nxt = dir_cur;
		delta_nxt = delta_cur;
		acc_nxt = acc_cur;
		span_nxt = span_cur;
		pulse = 1'b0;
		unique case (op)
			OP_TICK: begin
				if (tick_may) begin
					acc_nxt = tick_step ? acc_sub : acc_add;
				end
				if (tick_step) begin
					pos_nxt = dir_cur ? pos_inc : pos_dec;
					pulse = 1'b1;
				end
			end
			OP_START: begin
				tgt_nxt = val;
				dir_nxt = rc_dir;
				delta_nxt = rc_delta;
				span_nxt = mdelta;
				acc_nxt = -$signed(ACC_W'(mdelta >> 1));
			end
			OP_SETPOS: begin
				pos_nxt = val;
				dir_nxt = rc_dir;
				delta_nxt = rc_delta;
			end
			OP_JOGF: begin
				dir_nxt = 1'b1;
				pos_nxt = pos_inc;
				pulse = 1'b1;
			end
			OP_JOGR: begin
				dir_nxt = 1'b0;
				pos_nxt = pos_dec;
				pulse = 1'b1;
			end
			default: begin
			end
		endcase
	end

	// A tick reports the permission that gated it; other requests report it after the update.
	always_comb begin
		flags.step_pulse = pulse;
		flags.direction = dir_nxt;
		flags.may_step = (op == OP_TICK) ? tick_may
			: allowed(pos_nxt, tgt_nxt, dir_nxt, min_sw, max_sw);
		flags.on_target = (pos_nxt == tgt_nxt);
	end

endmodule

@@ rtl/stepper_axis_dda.sv @@
// One axis of a DDA stepper: a request register, the step logic and a result register.
// Each request (tick, start move, set position or a jog) is taken into an input
// register and applied to the axis state as it leaves that register. Its result lands
// in an output register at that moment, so a request can enter every cycle while the
// result side does not stall, and waits there until taken. The axis state registers are
// updated in the same cycle the result is captured, which makes back-to-back requests
// see each other's effects in order.
// Position arithmetic wraps at POS_WIDTH bits; the reported position is the low 32
// bits of the sign-extended position. A stall on the result side holds the result and
// backs up into the request side after the input register fills.
module stepper_axis_dda #(
	parameter int POS_WIDTH = sdda_pkg::POS_WIDTH_DEF
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 cmd_valid,
	output logic                                 cmd_stall,
	input  logic [sdda_pkg::OP_W-1:0]            opcode,
	input  logic signed [sdda_pkg::VALUE_W-1:0]  value,
	input  logic [sdda_pkg::DELTA_W-1:0]         move_span,
	input  logic                                 min_switch,
	input  logic                                 max_switch,
	output logic                                 res_valid,
	input  logic                                 res_stall,
	output logic                                 step_pulse,
	output logic                                 direction,
	output logic signed [sdda_pkg::VALUE_W-1:0]  position,
	output logic                                 may_step,
	output logic                                 on_target
);
	import sdda_pkg::*;

	localparam int MW = (POS_WIDTH > VALUE_W) ? POS_WIDTH : VALUE_W;

	logic                        valid_s1;
	logic [OP_W-1:0]             op_s1;
	logic signed [VALUE_W-1:0]   value_s1;
	logic [DELTA_W-1:0]          mdelta_s1;
	logic                        min_s1;
	logic                        max_s1;

	logic                        res_valid_s2;
	res_flags_t                  flags_s2;
	logic signed [VALUE_W-1:0]   pos_out_s2;

	logic signed [POS_WIDTH-1:0] pos_q;
	logic signed [POS_WIDTH-1:0] tgt_q;
	logic                        dir_q;
	logic [DELTA_W-1:0]          delta_q;
	logic signed [ACC_W-1:0]     acc_q;
	logic [DELTA_W-1:0]          span_q;

	logic signed [POS_WIDTH-1:0] pos_nxt;
	logic signed [POS_WIDTH-1:0] tgt_nxt;
	logic                        dir_nxt;
	logic [DELTA_W-1:0]          delta_nxt;
	logic signed [ACC_W-1:0]     acc_nxt;
	logic [DELTA_W-1:0]          span_nxt;
	res_flags_t                  flags;

	logic signed [MW-1:0]        val_ext;
	logic signed [POS_WIDTH-1:0] val_p;
	logic signed [MW-1:0]        pos_ext;
	logic                        load;
	logic                        advance;

	assign advance = valid_s1 && (!res_valid_s2 || !res_stall);
	assign cmd_stall = valid_s1 && !advance;
	assign load = cmd_valid && !cmd_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			res_valid_s2 <= 1'b0;
		end else begin
			valid_s1 <= load || (valid_s1 && !advance);
			if (advance) begin
				res_valid_s2 <= 1'b1;
			end else if (!res_stall) begin
				res_valid_s2 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			op_s1 <= opcode;
			value_s1 <= value;
			mdelta_s1 <= move_span;
			min_s1 <= min_switch;
			max_s1 <= max_switch;
		end
	end

	assign val_ext = MW'(value_s1);
	assign val_p = val_ext[POS_WIDTH-1:0];

	sdda_step #(
		.POS_WIDTH(POS_WIDTH)
	) u_step (
		.op       (op_s1),
		.val      (val_p),
		.mdelta   (mdelta_s1),
		.min_sw   (min_s1),
		.max_sw   (max_s1),
		.pos_cur  (pos_q),
		.tgt_cur  (tgt_q),
		.dir_cur  (dir_q),
		.delta_cur(delta_q),
		.acc_cur  (acc_q),
		.span_cur (span_q),
		.pos_nxt  (pos_nxt),
		.tgt_nxt  (tgt_nxt),
		.dir_nxt  (dir_nxt),
		.delta_nxt(delta_nxt),
		.acc_nxt  (acc_nxt),
		.span_nxt (span_nxt),
		.flags    (flags)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= '0;
			tgt_q <= '0;
			dir_q <= 1'b1;
			delta_q <= '0;
			acc_q <= '0;
			span_q <= '0;
		end else if (advance) begin
			pos_q <= pos_nxt;
			tgt_q <= tgt_nxt;
			dir_q <= dir_nxt;
			delta_q <= delta_nxt;
			acc_q <= acc_nxt;
			span_q <= span_nxt;
		end
	end

	assign pos_ext = MW'(pos_nxt);

	always_ff @(posedge clk) begin
		if (advance) begin
			flags_s2 <= flags;
			pos_out_s2 <= pos_ext[VALUE_W-1:0];
		end
	end

	assign res_valid = res_valid_s2;
	assign step_pulse = flags_s2.step_pulse;
	assign direction = flags_s2.direction;
	assign position = pos_out_s2;
	assign may_step = flags_s2.may_step;
	assign on_target = flags_s2.on_target;

`ifndef ASSERT_OFF
	a_stall_needs_full: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_stall |-> valid_s1)
		else $error("request side stalled with an empty input register");

	a_tick_gated: assert property (@(posedge clk) disable iff (!arst_n)
		(advance && op_s1 == OP_TICK && !flags.may_step) |-> !flags.step_pulse)
		else $error("tick stepped although stepping was not allowed");

	a_start_acc: assert property (@(posedge clk) disable iff (!arst_n)
		(advance && op_s1 == OP_START) |=> (acc_q[ACC_W-1] || acc_q == '0))
		else $error("accumulator positive right after a start move");

	a_jog_dir: assert property (@(posedge clk) disable iff (!arst_n)
		(advance && op_s1 == OP_JOGF) |=> (dir_q && res_valid_s2 && step_pulse))
		else $error("forward jog did not set direction and step");
`endif

endmodule
